// File: rtl/prqs_pkg.sv
`timescale 1ns / 1ps

package prqs_pkg;

    // field widths of the stream items
    localparam int TASK_W     = 12;
    localparam int PRIO_W     = 4;
    localparam int MASK_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // request kinds carried on s_tuser
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SCHED = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic pop_write;
        logic app_clear;
        logic app_link;
        logic finish;
    } prqs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_sched;
        logic in_add_ok;
        logic requeue;
        logic out_free;
    } prqs_status_t;

endpackage

// File: rtl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps

// Ready queue for one core: one FIFO per priority level (level 0 served first), kept as
// linked lists in a per-task link memory with head/tail tables and a non-empty bitmap.
// An add item (tuser 0) appends a task at its clamped priority; a schedule item (tuser 1)
// pops the best queued task, or the idle task 0, and re-appends the old running task (not
// the idle task) when it switches. Items are taken one at a time. The link memory has a
// single write port, so an add needs two writes, in a clear state and a link state, before
// the done state; an ignored add (task 0, or MAX_TASKS and above) goes straight to done, a
// schedule passes the pop write state, and one that re-queues the old task then clear and
// link. A finished result waits in the output register while the next item is accepted.
// The link and level memories are not cleared at reset and need no clearing pass.

module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int PRIORITY_LEVELS = 8,
    parameter int MAX_TASKS       = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // task_id[11:0], task_priority[15:12]
    input  logic                  s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // running_task[11:0], switched[12],
                                             // ready_mask[20:13], next_ready_task[32:21]
);

    prqs_cmd_t    cmd;
    prqs_status_t status;

    prqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prqs_datapath #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .MAX_TASKS       (MAX_TASKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/prqs_ctrl.sv
`timescale 1ns / 1ps

module prqs_ctrl
    import prqs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  prqs_status_t status,
    output prqs_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_POP_WR   = 5'b00010,
        ST_APP_CLR  = 5'b00100,
        ST_APP_LINK = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    if (status.in_sched)
                        state_next = ST_POP_WR;
                    else if (status.in_add_ok)
                        state_next = ST_APP_CLR;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_POP_WR:
            begin
                cmd.pop_write = 1'b1;
                state_next    = status.requeue ? ST_APP_CLR : ST_DONE;
            end
            ST_APP_CLR:
            begin
                cmd.app_clear = 1'b1;
                state_next    = ST_APP_LINK;
            end
            ST_APP_LINK:
            begin
                cmd.app_link = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/prqs_datapath.sv
`timescale 1ns / 1ps

module prqs_datapath
    import prqs_pkg::*;
#(
    parameter int PRIORITY_LEVELS = 8,
    parameter int MAX_TASKS       = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  prqs_cmd_t             cmd,
    output prqs_status_t          status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int LVL_W  = $clog2(PRIORITY_LEVELS);
    localparam int ADDR_W = $clog2(MAX_TASKS);

    // link and level memories, one write and one read port each
    logic [TASK_W-1:0] link_mem  [MAX_TASKS];
    logic [LVL_W-1:0]  level_mem [MAX_TASKS];

    logic [TASK_W-1:0] head_reg [PRIORITY_LEVELS];
    logic [TASK_W-1:0] head_next [PRIORITY_LEVELS];
    logic [TASK_W-1:0] tail_reg [PRIORITY_LEVELS];
    logic [TASK_W-1:0] tail_next [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] nonempty_reg;
    logic [PRIORITY_LEVELS-1:0] nonempty_next;
    logic [TASK_W-1:0] current_task_reg;
    logic [TASK_W-1:0] current_task_next;
    logic [LVL_W-1:0]  current_level_reg;
    logic [LVL_W-1:0]  current_level_next;

    logic              pop_valid_reg;
    logic [LVL_W-1:0]  pop_lvl_reg;
    logic [TASK_W-1:0] pop_task_reg;
    logic [TASK_W-1:0] rd_link_reg;
    logic [LVL_W-1:0]  rd_level_reg;
    logic [TASK_W-1:0] app_task_reg;
    logic [TASK_W-1:0] app_task_next;
    logic [LVL_W-1:0]  app_lvl_reg;
    logic [LVL_W-1:0]  app_lvl_next;
    logic              lvl_wr_reg;
    logic              lvl_wr_next;
    logic              sw_reg;
    logic              sw_next;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [TASK_W-1:0] in_tid;
    logic [PRIO_W-1:0] in_prio;
    logic [LVL_W-1:0]  in_lvl;
    logic              in_add_ok;
    logic [LVL_W-1:0]  best_lvl;
    logic              best_found;
    logic [TASK_W-1:0] best_head;
    logic              do_switch;
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [TASK_W-1:0] link_wdata;
    logic [MASK_W-1:0] ready_mask;
    logic [TASK_W-1:0] next_ready;
    logic [31:0]       mask_wide;

    // input item decode, priority clamped to the top level
    assign in_tid    = s_tdata[TASK_W-1:0];
    assign in_prio   = s_tdata[TASK_W +: PRIO_W];
    assign in_add_ok = (in_tid != '0) && (32'(in_tid) < MAX_TASKS);
    assign in_lvl    = (32'(in_prio) >= PRIORITY_LEVELS) ? LVL_W'(PRIORITY_LEVELS - 1)
                                                         : LVL_W'(in_prio);

    // best non-empty level, lowest index wins
    always_comb
    begin
        best_lvl = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
                best_lvl = LVL_W'(i);
        end
    end
    assign best_found = |nonempty_reg;
    assign best_head  = head_reg[best_lvl];

    assign do_switch = (pop_task_reg != current_task_reg);

    assign status.in_sched  = (s_tuser == REQ_SCHED);
    assign status.in_add_ok = in_add_ok;
    assign status.requeue   = do_switch && (current_task_reg != '0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // queue table updates and link memory write port
    always_comb
    begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        nonempty_next      = nonempty_reg;
        current_task_next  = current_task_reg;
        current_level_next = current_level_reg;
        app_task_next      = app_task_reg;
        app_lvl_next       = app_lvl_reg;
        lvl_wr_next        = lvl_wr_reg;
        sw_next            = sw_reg;
        link_we            = 1'b0;
        link_waddr         = ADDR_W'(app_task_reg);
        link_wdata         = '0;
        if (cmd.accept)
        begin
            sw_next = 1'b0;
            if (s_tuser == REQ_ADD)
            begin
                app_task_next = in_tid;
                app_lvl_next  = in_lvl;
                lvl_wr_next   = 1'b1;
            end
        end
        if (cmd.pop_write)
        begin
            // unlink the popped head
            if (pop_valid_reg)
            begin
                head_next[pop_lvl_reg] = rd_link_reg;
                if (rd_link_reg == '0)
                begin
                    tail_next[pop_lvl_reg]     = '0;
                    nonempty_next[pop_lvl_reg] = 1'b0;
                end
                link_we    = 1'b1;
                link_waddr = ADDR_W'(pop_task_reg);
            end
            // switch, the old task becomes the append target
            if (do_switch)
            begin
                sw_next            = 1'b1;
                current_task_next  = pop_task_reg;
                current_level_next = (pop_task_reg != '0) ? rd_level_reg : '0;
                app_task_next      = current_task_reg;
                app_lvl_next       = current_level_reg;
                lvl_wr_next        = 1'b0;
            end
        end
        if (cmd.app_clear)
        begin
            link_we = 1'b1;
        end
        if (cmd.app_link)
        begin
            if (nonempty_reg[app_lvl_reg])
            begin
                link_we    = 1'b1;
                link_waddr = ADDR_W'(tail_reg[app_lvl_reg]);
                link_wdata = app_task_reg;
            end
            else
            begin
                head_next[app_lvl_reg] = app_task_reg;
            end
            tail_next[app_lvl_reg]     = app_task_reg;
            nonempty_next[app_lvl_reg] = 1'b1;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (cmd.app_clear && lvl_wr_reg)
            level_mem[ADDR_W'(app_task_reg)] <= app_lvl_reg;
        if (cmd.accept)
        begin
            rd_link_reg  <= link_mem[ADDR_W'(best_head)];
            rd_level_reg <= level_mem[ADDR_W'(best_head)];
        end
    end

    // pop capture at accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pop_valid_reg <= best_found;
            pop_lvl_reg   <= best_lvl;
            pop_task_reg  <= best_found ? best_head : '0;
        end
    end

    // queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg          <= '{default: '0};
            tail_reg          <= '{default: '0};
            nonempty_reg      <= '0;
            current_task_reg  <= '0;
            current_level_reg <= '0;
        end
        else
        begin
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            nonempty_reg      <= nonempty_next;
            current_task_reg  <= current_task_next;
            current_level_reg <= current_level_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        app_task_reg <= app_task_next;
        app_lvl_reg  <= app_lvl_next;
        lvl_wr_reg   <= lvl_wr_next;
        sw_reg       <= sw_next;
    end

    // result fields
    assign mask_wide  = 32'(nonempty_reg);
    assign ready_mask = mask_wide[MASK_W-1:0];
    assign next_ready = best_found ? best_head : '0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            m_tdata_reg <= OUT_DATA_W'({next_ready, ready_mask, sw_reg, current_task_reg});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/priority_ready_queue_scheduler_test.sv
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_test;

    import prqs_pkg::*;

    localparam int LEVELS       = 8;
    localparam int TASK_SLOTS   = 4096;
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam int ROW_COUNT    = 24;

    // one result item, laid out as m_tdata[32:0] from the highest bit down
    typedef struct packed {
        logic [TASK_W-1:0] next_ready;
        logic [MASK_W-1:0] ready_mask;
        logic              switched;
        logic [TASK_W-1:0] running;
    } sched_result_t;

    // one row of the directed table
    typedef struct packed {
        logic              req;
        logic [TASK_W-1:0] id;
        logic [PRIO_W-1:0] prio;
        logic              known;
        sched_result_t     want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    // ready queue image kept by the testbench
    bit [TASK_W-1:0] link_of_task [TASK_SLOTS];
    bit [2:0]        level_of_task [TASK_SLOTS];
    bit [TASK_W-1:0] head_tbl [LEVELS];
    bit [TASK_W-1:0] tail_tbl [LEVELS];
    bit [LEVELS-1:0] ready_bits;
    bit [TASK_W-1:0] running_now;
    bit [2:0]        running_level;

    // tasks ever handed to the queue, for well-formed and duplicate adds
    bit              task_placed [TASK_SLOTS];
    logic [TASK_W-1:0] placed_ids[$];

    sched_result_t pending_results[$];
    int            error_count;
    int            sender_idle_pct;
    int            receiver_stall_pct;
    int            hold_request;

    priority_ready_queue_scheduler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // best non-empty level, or LEVELS when nothing is queued
    function automatic int best_level();
        for (int l = 0; l < LEVELS; l++)
        begin
            if (ready_bits[l])
                return l;
        end
        return LEVELS;
    endfunction

    // link a task behind the tail of its level
    task automatic queue_append(input bit [TASK_W-1:0] t, input bit [2:0] l);
        link_of_task[t] = '0;
        if (ready_bits[l])
            link_of_task[tail_tbl[l]] = t;
        else
            head_tbl[l] = t;
        tail_tbl[l]   = t;
        ready_bits[l] = 1'b1;
    endtask

    // unlink the head of the best level, idle task when all levels are empty
    task automatic queue_pop(output bit [TASK_W-1:0] t);
        int l;
        l = best_level();
        t = '0;
        if (l < LEVELS)
        begin
            t           = head_tbl[l];
            head_tbl[l] = link_of_task[t];
            if (head_tbl[l] == 0)
            begin
                tail_tbl[l]   = '0;
                ready_bits[l] = 1'b0;
            end
            link_of_task[t] = '0;
        end
    endtask

    // apply one request to the queue image and work out its result item
    task automatic predict_request(input logic req, input logic [TASK_W-1:0] id,
                                   input logic [PRIO_W-1:0] prio, output sched_result_t r);
        bit [TASK_W-1:0] popped;
        bit [2:0]        lvl;
        int              best;
        r = '0;
        if (req == REQ_ADD)
        begin
            if (id != 0)
            begin
                lvl = (prio >= LEVELS) ? 3'(LEVELS - 1) : prio[2:0];
                level_of_task[id] = lvl;
                queue_append(id, lvl);
            end
        end
        else
        begin
            queue_pop(popped);
            if (popped != running_now)
            begin
                // old task goes back to its own level unless it is the idle task
                if (running_now != 0)
                    queue_append(running_now, running_level);
                running_now   = popped;
                running_level = (popped != 0) ? level_of_task[popped] : 3'd0;
                r.switched    = 1'b1;
            end
        end
        best         = best_level();
        r.running    = running_now;
        r.ready_mask = ready_bits;
        r.next_ready = (best < LEVELS) ? head_tbl[best] : '0;
    endtask

    // offer one item, wait for the handshake, then record what it should produce
    task automatic issue_request(input logic req, input logic [TASK_W-1:0] id,
                                 input logic [PRIO_W-1:0] prio, input logic known,
                                 input sched_result_t typed);
        sched_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {prio, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(req, id, prio, predicted);
        pending_results.push_back(known ? typed : predicted);
        if (req == REQ_ADD && id != 0 && !task_placed[id])
        begin
            task_placed[id] = 1'b1;
            placed_ids.push_back(id);
        end
    endtask

    function automatic stim_row_t row(input logic req, input int id, input int prio,
                                      input logic known, input int run, input logic sw,
                                      input int mask, input int nxt);
        stim_row_t r;
        r.req             = req;
        r.id              = id[TASK_W-1:0];
        r.prio            = prio[PRIO_W-1:0];
        r.known           = known;
        r.want.running    = run[TASK_W-1:0];
        r.want.switched   = sw;
        r.want.ready_mask = mask[MASK_W-1:0];
        r.want.next_ready = nxt[TASK_W-1:0];
        return r;
    endfunction

    // directed items; expectations typed in where they are obvious
    function automatic stim_row_t directed_row(input int i);
        stim_row_t r;
        case (i)
            0:  r = row(REQ_SCHED, 0,      0,  1, 0, 0, 8'h00, 0);      // empty queue
            1:  r = row(REQ_ADD,   0,      0,  1, 0, 0, 8'h00, 0);      // idle task add
            2:  r = row(REQ_ADD,   12'hfff, 15, 1, 0, 0, 8'h80, 12'hfff); // clamped priority
            3:  r = row(REQ_ADD,   1,      0,  1, 0, 0, 8'h81, 1);
            4:  r = row(REQ_SCHED, 0,      0,  1, 1, 1, 8'h80, 12'hfff);
            5:  r = row(REQ_ADD,   1,      0,  1, 1, 0, 8'h81, 1);      // running task queued
            6:  r = row(REQ_SCHED, 0,      0,  1, 1, 0, 8'h80, 12'hfff); // pops itself
            7:  r = row(REQ_ADD,   12'haaa, 3,  1, 1, 0, 8'h88, 12'haaa);
            8:  r = row(REQ_ADD,   12'h555, 8,  1, 1, 0, 8'h88, 12'haaa);
            9:  r = row(REQ_ADD,   2,      0,  1, 1, 0, 8'h89, 2);
            10: r = row(REQ_SCHED, 12'hfff, 15, 1, 2, 1, 8'h89, 1);     // old task re-queued
            11: r = row(REQ_ADD,   12'h800, 5,  0, 0, 0, 0, 0);
            12: r = row(REQ_ADD,   12'h800, 5,  0, 0, 0, 0, 0);         // queued twice
            13: r = row(REQ_ADD,   0,      15, 0, 0, 0, 0, 0);
            14: r = row(REQ_ADD,   3,      1,  0, 0, 0, 0, 0);
            15: r = row(REQ_ADD,   12'h7ff, 7,  0, 0, 0, 0, 0);
            16: r = row(REQ_ADD,   12'hfff, 7,  0, 0, 0, 0, 0);         // queued twice
            default: r = row(REQ_SCHED, 0, 0, 0, 0, 0, 0, 0);
        endcase
        return r;
    endfunction

    // result side: check accepted items and decide tready
    initial
    begin
        int            hold_left;
        int            reported;
        sched_result_t got;
        sched_result_t want;
        hold_left = 0;
        reported  = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[32:0];
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        reported++;
                        $display("unexpected result item: running %0d switched %0d mask %02h next %0d",
                                 got.running, got.switched, got.ready_mask, got.next_ready);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.running !== want.running || got.switched !== want.switched ||
                        got.ready_mask !== want.ready_mask || got.next_ready !== want.next_ready)
                    begin
                        error_count++;
                        if (reported < REPORT_LIMIT)
                        begin
                            reported++;
                            $display("mismatch: running %0d/%0d switched %0d/%0d mask %02h/%02h next %0d/%0d (exp/got)",
                                     want.running, got.running, want.switched, got.switched,
                                     want.ready_mask, got.ready_mask, want.next_ready, got.next_ready);
                        end
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // run time limit
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        stim_row_t         r;
        int                sent;
        int                pick;
        logic [TASK_W-1:0] id;
        int                idle_tbl [4];
        int                stall_tbl [4];
        idle_tbl  = '{0, 76, 0, 20};
        stall_tbl = '{0, 0, 76, 20};
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_ADD;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            r = directed_row(i);
            issue_request(r.req, r.id, r.prio, r.known, r.want);
        end

        // random part, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct    = idle_tbl[ph];
            receiver_stall_pct = stall_tbl[ph];
            // receiver holds off while the sender keeps offering
            if (ph == 0)
                hold_request = HOLD_CYCLES;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 68)
                begin
                    issue_request(REQ_SCHED, 12'($urandom), 4'($urandom), 1'b0, '0);
                    sent++;
                end
                else if (pick < 90)
                begin
                    // well-formed add of a task not seen before
                    do
                        id = 12'($urandom_range(1, TASK_SLOTS - 1));
                    while (task_placed[id]);
                    issue_request(REQ_ADD, id, 4'($urandom_range(15)), 1'b0, '0);
                    sent++;
                end
                else if (pick < 96)
                begin
                    // task queued twice: the running one or any known one
                    if (pick < 93 && running_now != 0)
                        id = running_now;
                    else
                        id = placed_ids[$urandom_range(placed_ids.size() - 1)];
                    issue_request(REQ_ADD, id, 4'($urandom_range(15)), 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // idle task add, ignored by the block
                    issue_request(REQ_ADD, '0, 4'($urandom_range(15)), 1'b0, '0);
                end
            end
            // sender pauses until every result is back
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
